/* design/sgr_pkg.sv */
// ----------------------------------------------------------------------------
// sgr_pkg
// Shared constants, command and status types for the stereo gain ramp block.
// ----------------------------------------------------------------------------
package sgr_pkg;

  // default parameter values
  localparam int MAX_BLOCK_DEF   = 4096;
  localparam int SAMPLE_BITS_DEF = 24;

  // fixed field widths
  localparam int GAIN_W     = 24;
  localparam int STEP_W     = 16;
  localparam int ALPHA_W    = 16;
  localparam int G_W        = 28;   // combined Q8.20 gain
  localparam int SUM_W      = 64;
  localparam int ROOT_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // reset values of the registers
  localparam logic [GAIN_W-1:0]  UNITY          = 24'd1048576;
  localparam logic [STEP_W-1:0]  RAMP_STEPS_RST = 16'd882;
  localparam logic [ALPHA_W-1:0] VU_ALPHA_RST   = 16'd63052;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FADER     = 3'd0,
    REG_PAN_LEFT  = 3'd1,
    REG_PAN_RIGHT = 3'd2,
    REG_RAMP      = 3'd3,
    REG_VU_ALPHA  = 3'd4
  } reg_e;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_RAMP_CHK,
    OP_RAMP_DELTA,
    OP_RAMP_STEP,
    OP_MUL_GAIN,
    OP_SET_GAIN,
    OP_MUL_X,
    OP_SET_Y,
    OP_MUL_SQ,
    OP_ACC,
    OP_COUNT,
    OP_MEAN_DIV,
    OP_ROOT,
    OP_MUL_VU_OLD,
    OP_HOLD_VU,
    OP_MUL_VU_NEW,
    OP_SET_VU,
    OP_OUT
  } op_e;

  // controller states
  typedef enum logic [4:0] {
    S_IDLE,
    S_RAMP,
    S_RDIV,
    S_STEP,
    S_GMUL,
    S_GSET,
    S_XMUL,
    S_YSET,
    S_SQMUL,
    S_ACC,
    S_CNT,
    S_MDIV,
    S_MDIVW,
    S_ROOTW,
    S_VMUL1,
    S_VHOLD,
    S_VMUL2,
    S_VSET,
    S_OUT
  } state_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic [2:0] ramp_chg;
    logic       iter_busy;
    logic       block_end;
    logic       out_free;
  } sts_t;

endpackage

/* design/sgr_iter.sv */
// ----------------------------------------------------------------------------
// sgr_iter
// Shared iterative unit: restoring divider (one quotient bit per cycle) and
// integer square root (one root bit per cycle).
// ----------------------------------------------------------------------------
module sgr_iter #(
  parameter int DVS_W = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_div_i,
  input  logic                      start_sqrt_i,
  input  logic [sgr_pkg::SUM_W-1:0] operand_i,
  input  logic [DVS_W-1:0]          divisor_i,
  output logic                      busy_o,
  output logic [sgr_pkg::SUM_W-1:0] result_o
);
  import sgr_pkg::*;

  localparam int CNT_W  = $clog2(SUM_W + 1);
  localparam int SREM_W = ROOT_W + 3;

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              sqrt_q, sqrt_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [DVS_W:0]    rem_q, rem_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [SREM_W-1:0] srem_q, srem_d;

  logic [DVS_W:0]    shifted;
  logic              div_fits;
  logic [SREM_W-1:0] r2, trial;
  logic              root_fits;

  // one divide step and one root step
  always_comb begin
    shifted   = {rem_q[DVS_W-1:0], quo_q[SUM_W-1]};
    div_fits  = shifted >= {1'b0, dvs_q};
    r2        = {srem_q[SREM_W-3:0], quo_q[SUM_W-1 -: 2]};
    trial     = {1'b0, root_q, 2'b01};
    root_fits = r2 >= trial;
  end

  // sequence the iterations
  always_comb begin
    cnt_d  = cnt_q;
    sqrt_d = sqrt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    root_d = root_q;
    srem_d = srem_q;
    if (start_div_i) begin
      cnt_d  = CNT_W'(SUM_W);
      sqrt_d = 1'b0;
      quo_d  = operand_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (start_sqrt_i) begin
      cnt_d  = CNT_W'(ROOT_W);
      sqrt_d = 1'b1;
      quo_d  = operand_i;
      root_d = '0;
      srem_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (sqrt_q) begin
        srem_d = root_fits ? r2 - trial : r2;
        root_d = {root_q[ROOT_W-2:0], root_fits};
        quo_d  = {quo_q[SUM_W-3:0], 2'b00};
      end else begin
        rem_d = div_fits ? shifted - {1'b0, dvs_q} : shifted;
        quo_d = {quo_q[SUM_W-2:0], div_fits};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sqrt_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      sqrt_q <= sqrt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    root_q <= root_d;
    srem_q <= srem_d;
  end

  assign busy_o   = cnt_q != '0;
  assign result_o = sqrt_q ? SUM_W'(root_q) : quo_q;

endmodule

/* design/sgr_dp.sv */
// ----------------------------------------------------------------------------
// sgr_dp
// Datapath: configuration registers, gain ramps, shared multiplier, meter
// accumulators and the output register.
// ----------------------------------------------------------------------------
module sgr_dp #(
  parameter int MAX_BLOCK   = sgr_pkg::MAX_BLOCK_DEF,
  parameter int SAMPLE_BITS = sgr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [sgr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sgr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic signed [SAMPLE_BITS-1:0]  left_in_i,
  input  logic signed [SAMPLE_BITS-1:0]  right_in_i,
  input  logic                           last_in_block_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output logic signed [SAMPLE_BITS-1:0]  left_out_o,
  output logic signed [SAMPLE_BITS-1:0]  right_out_o,
  output logic                           meters_valid_o,
  output logic [SAMPLE_BITS-1:0]         peak_left_o,
  output logic [SAMPLE_BITS-1:0]         peak_right_o,
  output logic [SAMPLE_BITS-1:0]         vu_left_o,
  output logic [SAMPLE_BITS-1:0]         vu_right_o,
  input  sgr_pkg::cmd_t                  cmd_i,
  output sgr_pkg::sts_t                  sts_o
);
  import sgr_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int CNT_W = $clog2(MAX_BLOCK + 1);
  localparam int DVS_W = (CNT_W > STEP_W) ? CNT_W : STEP_W;
  localparam int A_W   = ((SB > GAIN_W) ? SB : GAIN_W) + 1;
  localparam int B_W   = ((SB + 1) > 30) ? (SB + 1) : 30;
  localparam int P_W   = A_W + B_W;

  // configuration
  logic [GAIN_W-1:0]  fader_tgt_q, pan_l_tgt_q, pan_r_tgt_q;
  logic [STEP_W-1:0]  ramp_steps_q;
  logic [ALPHA_W-1:0] vu_alpha_q;

  // ramps: 0 fader, 1 left balance, 2 right balance
  logic [GAIN_W-1:0]        cur_q[3];
  logic [GAIN_W-1:0]        app_q[3];
  logic signed [GAIN_W:0]   dlt_q[3];
  logic [STEP_W-1:0]        left_q[3];
  logic                     neg_q[3];
  logic [GAIN_W-1:0]        tgt[3];

  // sample and meter state
  logic signed [SB-1:0]     x_q[2];
  logic signed [SB-1:0]     y_q[2];
  logic                     last_q;
  logic [G_W-1:0]           g_q;
  logic signed [P_W-1:0]    prod_q;
  logic signed [P_W-1:0]    acc_q;
  logic [SB-1:0]            peak_q[2];
  logic [SB-1:0]            pk_hold_q[2];
  logic [SUM_W-1:0]         sum_q[2];
  logic [CNT_W-1:0]         count_q;
  logic [SB-1:0]            vu_q[2];
  logic                     end_q;

  // output register
  logic                     out_valid_q;
  logic signed [SB-1:0]     lo_q, ro_q;
  logic                     mv_q;
  logic [SB-1:0]            pl_q, pr_q, vl_q, vr_q;

  // iterative unit
  logic                     it_start_div, it_start_sqrt, it_busy;
  logic [SUM_W-1:0]         it_operand, it_result;
  logic [DVS_W-1:0]         it_divisor;

  // working signals
  logic [1:0]               ridx;
  logic                     ch;
  logic [STEP_W-1:0]        n_eff;
  logic signed [GAIN_W:0]   diff;
  logic [GAIN_W-1:0]        diff_mag;
  logic signed [A_W-1:0]    mul_a;
  logic signed [B_W-1:0]    mul_b;
  logic signed [P_W-1:0]    prod_d;
  logic                     mul_en;
  logic [P_W-1:0]           gsum;
  logic signed [P_W-1:0]    ysum, y_full;
  logic                     ovf_hi, ovf_lo;
  logic signed [SB-1:0]     y_sat;
  logic [SB-1:0]            mag;
  logic [SUM_W:0]           sum_ext;
  logic [CNT_W-1:0]         cnt_inc;
  logic                     blk_end;
  logic [P_W-1:0]           vsum;
  logic [GAIN_W-1:0]        bal;
  logic [SB-1:0]            rms;

  assign tgt[0] = fader_tgt_q;
  assign tgt[1] = pan_l_tgt_q;
  assign tgt[2] = pan_r_tgt_q;
  assign ridx   = cmd_i.idx;
  assign ch     = cmd_i.idx[0];

  // ramp set-up terms
  always_comb begin
    n_eff    = (ramp_steps_q == '0) ? STEP_W'(1) : ramp_steps_q;
    diff     = $signed({1'b0, tgt[ridx]}) - $signed({1'b0, cur_q[ridx]});
    diff_mag = diff[GAIN_W] ? GAIN_W'(-diff) : diff[GAIN_W-1:0];
  end

  // drive the shared iterative unit
  always_comb begin
    it_start_div  = 1'b0;
    it_start_sqrt = 1'b0;
    it_operand    = '0;
    it_divisor    = '0;
    unique case (cmd_i.op)
      OP_RAMP_CHK: begin
        it_start_div = tgt[ridx] != app_q[ridx];
        it_operand   = SUM_W'(diff_mag);
        it_divisor   = DVS_W'(n_eff);
      end
      OP_MEAN_DIV: begin
        it_start_div = 1'b1;
        it_operand   = sum_q[ch];
        it_divisor   = DVS_W'(count_q);
      end
      OP_ROOT: begin
        it_start_sqrt = 1'b1;
        it_operand    = it_result;
      end
      default: begin
        it_start_div = 1'b0;
      end
    endcase
  end

  sgr_iter #(
    .DVS_W(DVS_W)
  ) u_iter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_div_i (it_start_div),
    .start_sqrt_i(it_start_sqrt),
    .operand_i   (it_operand),
    .divisor_i   (it_divisor),
    .busy_o      (it_busy),
    .result_o    (it_result)
  );

  // select multiplier operands
  always_comb begin
    bal    = ch ? cur_q[2] : cur_q[1];
    mag    = y_q[ch][SB-1] ? SB'(-y_q[ch]) : y_q[ch];
    rms    = it_result[SB-1:0];
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (cmd_i.op)
      OP_MUL_GAIN: begin
        mul_a = A_W'(cur_q[0]);
        mul_b = B_W'(bal);
      end
      OP_MUL_X: begin
        mul_a = {{(A_W-SB){x_q[ch][SB-1]}}, x_q[ch]};
        mul_b = B_W'(g_q);
      end
      OP_MUL_SQ: begin
        mul_a = A_W'(mag);
        mul_b = B_W'(mag);
      end
      OP_MUL_VU_OLD: begin
        mul_a = A_W'(vu_q[ch]);
        mul_b = B_W'(vu_alpha_q);
      end
      OP_MUL_VU_NEW: begin
        mul_a = A_W'(rms);
        mul_b = B_W'(17'h10000 - {1'b0, vu_alpha_q});
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // rounding, saturation and accumulation terms
  always_comb begin
    gsum    = prod_q + P_W'(1 << 19);
    ysum    = prod_q + P_W'(1 << 19);
    y_full  = ysum >>> 20;
    ovf_hi  = !y_full[P_W-1] && (|y_full[P_W-2:SB-1]);
    ovf_lo  = y_full[P_W-1] && !(&y_full[P_W-2:SB-1]);
    if (ovf_hi) begin
      y_sat = {1'b0, {(SB-1){1'b1}}};
    end else if (ovf_lo) begin
      y_sat = {1'b1, {(SB-1){1'b0}}};
    end else begin
      y_sat = y_full[SB-1:0];
    end
    sum_ext = {1'b0, sum_q[ch]} + {1'b0, SUM_W'(prod_q[2*SB-1:0])};
    cnt_inc = count_q + 1'b1;
    blk_end = last_q || (cnt_inc >= CNT_W'(MAX_BLOCK));
    vsum    = acc_q + prod_q + P_W'(1 << 15);
  end

  // control registers: configuration, ramps, meters, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fader_tgt_q  <= UNITY;
      pan_l_tgt_q  <= UNITY;
      pan_r_tgt_q  <= UNITY;
      ramp_steps_q <= RAMP_STEPS_RST;
      vu_alpha_q   <= VU_ALPHA_RST;
      for (int r = 0; r < 3; r++) begin
        cur_q[r]  <= UNITY;
        app_q[r]  <= UNITY;
        dlt_q[r]  <= '0;
        left_q[r] <= '0;
        neg_q[r]  <= 1'b0;
      end
      for (int c = 0; c < 2; c++) begin
        peak_q[c] <= '0;
        sum_q[c]  <= '0;
        vu_q[c]   <= '0;
      end
      count_q     <= '0;
      end_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // take configuration writes
      if (cfg_valid_i) begin
        unique case (reg_e'(cfg_index_i))
          REG_FADER:     fader_tgt_q  <= cfg_data_i[GAIN_W-1:0];
          REG_PAN_LEFT:  pan_l_tgt_q  <= cfg_data_i[GAIN_W-1:0];
          REG_PAN_RIGHT: pan_r_tgt_q  <= cfg_data_i[GAIN_W-1:0];
          REG_RAMP:      ramp_steps_q <= cfg_data_i[STEP_W-1:0];
          REG_VU_ALPHA:  vu_alpha_q   <= cfg_data_i[ALPHA_W-1:0];
          default:       ;
        endcase
      end
      // load a new output transaction, or drop the current one once taken
      if (cmd_i.op == OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i.op)
        OP_RAMP_CHK: begin
          if (tgt[ridx] != app_q[ridx]) begin
            app_q[ridx]  <= tgt[ridx];
            left_q[ridx] <= n_eff;
            neg_q[ridx]  <= diff[GAIN_W];
          end
        end
        OP_RAMP_DELTA: begin
          dlt_q[ridx] <= neg_q[ridx] ? -$signed({1'b0, it_result[GAIN_W-1:0]})
                                     :  $signed({1'b0, it_result[GAIN_W-1:0]});
        end
        OP_RAMP_STEP: begin
          for (int r = 0; r < 3; r++) begin
            if (left_q[r] == '0) begin
              cur_q[r] <= app_q[r];
            end else begin
              left_q[r] <= left_q[r] - 1'b1;
              if (left_q[r] != STEP_W'(1)) begin
                cur_q[r] <= GAIN_W'($signed({1'b0, cur_q[r]}) + dlt_q[r]);
              end else begin
                cur_q[r] <= app_q[r];
              end
            end
          end
        end
        OP_ACC: begin
          if (mag > peak_q[ch]) begin
            peak_q[ch] <= mag;
          end
          sum_q[ch] <= sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
        end
        OP_COUNT: begin
          count_q <= cnt_inc;
          end_q   <= blk_end;
        end
        OP_SET_VU: begin
          vu_q[ch]   <= vsum[16 +: SB];
          peak_q[ch] <= '0;
          sum_q[ch]  <= '0;
        end
        OP_OUT: begin
          if (end_q) begin
            count_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= prod_d;
    end
    unique case (cmd_i.op)
      OP_LOAD: begin
        x_q[0] <= left_in_i;
        x_q[1] <= right_in_i;
        last_q <= last_in_block_i;
      end
      OP_SET_GAIN: g_q      <= gsum[20 +: G_W];
      OP_SET_Y:    y_q[ch]  <= y_sat;
      OP_HOLD_VU: begin
        acc_q         <= prod_q;
        pk_hold_q[ch] <= peak_q[ch];
      end
      OP_OUT: begin
        lo_q <= y_q[0];
        ro_q <= y_q[1];
        mv_q <= end_q;
        pl_q <= end_q ? pk_hold_q[0] : '0;
        pr_q <= end_q ? pk_hold_q[1] : '0;
        vl_q <= end_q ? vu_q[0] : '0;
        vr_q <= end_q ? vu_q[1] : '0;
      end
      default: ;
    endcase
  end

  // status to the controller
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sts_o.ramp_chg[r] = tgt[r] != app_q[r];
    end
    sts_o.iter_busy = it_busy;
    sts_o.block_end = blk_end;
    sts_o.out_free  = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o    = out_valid_q;
  assign left_out_o     = lo_q;
  assign right_out_o    = ro_q;
  assign meters_valid_o = mv_q;
  assign peak_left_o    = pl_q;
  assign peak_right_o   = pr_q;
  assign vu_left_o      = vl_q;
  assign vu_right_o     = vr_q;

endmodule

/* design/sgr_ctrl.sv */
// ----------------------------------------------------------------------------
// sgr_ctrl
// Controller: steps one sample pair through ramp update, gain, metering and
// output by issuing one datapath command per cycle, or none while it waits.
// ----------------------------------------------------------------------------
module sgr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output sgr_pkg::cmd_t cmd_o,
  input  sgr_pkg::sts_t sts_i
);
  import sgr_pkg::*;

  state_e     state_q, state_d;
  logic [1:0] idx_q, idx_d;

  // next state
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_RAMP;
          idx_d   = '0;
        end
      end
      S_RAMP, S_RDIV: begin
        if (state_q == S_RAMP && sts_i.ramp_chg[idx_q]) begin
          state_d = S_RDIV;
        end else if (state_q == S_RDIV && sts_i.iter_busy) begin
          state_d = S_RDIV;
        end else if (idx_q == 2'd2) begin
          state_d = S_STEP;
        end else begin
          state_d = S_RAMP;
          idx_d   = idx_q + 1'b1;
        end
      end
      S_STEP: begin
        state_d = S_GMUL;
        idx_d   = '0;
      end
      S_GMUL:  state_d = S_GSET;
      S_GSET:  state_d = S_XMUL;
      S_XMUL:  state_d = S_YSET;
      S_YSET:  state_d = S_SQMUL;
      S_SQMUL: state_d = S_ACC;
      S_ACC: begin
        if (idx_q[0]) begin
          state_d = S_CNT;
        end else begin
          state_d = S_GMUL;
          idx_d   = 2'd1;
        end
      end
      S_CNT: begin
        state_d = sts_i.block_end ? S_MDIV : S_OUT;
        idx_d   = '0;
      end
      S_MDIV: state_d = S_MDIVW;
      S_MDIVW: begin
        if (!sts_i.iter_busy) begin
          state_d = S_ROOTW;
        end
      end
      S_ROOTW: begin
        if (!sts_i.iter_busy) begin
          state_d = S_VMUL1;
        end
      end
      S_VMUL1: state_d = S_VHOLD;
      S_VHOLD: state_d = S_VMUL2;
      S_VMUL2: state_d = S_VSET;
      S_VSET: begin
        if (idx_q[0]) begin
          state_d = S_OUT;
        end else begin
          state_d = S_MDIV;
          idx_d   = 2'd1;
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o.op   = OP_NONE;
    cmd_o.idx  = idx_q;
    in_stall_o = state_q != S_IDLE;
    unique case (state_q)
      S_IDLE:  cmd_o.op = in_valid_i ? OP_LOAD : OP_NONE;
      S_RAMP:  cmd_o.op = OP_RAMP_CHK;
      S_RDIV:  cmd_o.op = sts_i.iter_busy ? OP_NONE : OP_RAMP_DELTA;
      S_STEP:  cmd_o.op = OP_RAMP_STEP;
      S_GMUL:  cmd_o.op = OP_MUL_GAIN;
      S_GSET:  cmd_o.op = OP_SET_GAIN;
      S_XMUL:  cmd_o.op = OP_MUL_X;
      S_YSET:  cmd_o.op = OP_SET_Y;
      S_SQMUL: cmd_o.op = OP_MUL_SQ;
      S_ACC:   cmd_o.op = OP_ACC;
      S_CNT:   cmd_o.op = OP_COUNT;
      S_MDIV:  cmd_o.op = OP_MEAN_DIV;
      S_MDIVW: cmd_o.op = sts_i.iter_busy ? OP_NONE : OP_ROOT;
      S_ROOTW: cmd_o.op = OP_NONE;
      S_VMUL1: cmd_o.op = OP_MUL_VU_OLD;
      S_VHOLD: cmd_o.op = OP_HOLD_VU;
      S_VMUL2: cmd_o.op = OP_MUL_VU_NEW;
      S_VSET:  cmd_o.op = OP_SET_VU;
      S_OUT:   cmd_o.op = sts_i.out_free ? OP_OUT : OP_NONE;
      default: cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

/* design/stereo_gain_ramp_with_peak_vu_meter_top.sv */
// ----------------------------------------------------------------------------
// stereo_gain_ramp_with_peak_vu_meter_top
// Stereo fader and balance gain with linear ramps and a block peak/VU meter.
// ----------------------------------------------------------------------------
// One sample pair is worked on at a time. A pair passes from acceptance
// through ramp update, gain and metering to the output register, and the
// controller returns to idle before it takes the next pair. Each ramp whose
// target changed adds a pass through the shared divider (one quotient bit per
// cycle over 64 bits) and the delta update, and a block end adds two 64-bit
// mean divisions, two 32-step square roots and the two VU blends. All
// products go through one shared multiplier, one per cycle. A finished
// transaction waits in the output register while the next pair is taken in;
// a stalled output holds the next pair in the controller until the register
// frees up.
module stereo_gain_ramp_with_peak_vu_meter_top #(
  parameter int MAX_BLOCK   = sgr_pkg::MAX_BLOCK_DEF,
  parameter int SAMPLE_BITS = sgr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sgr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sgr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]  left_in_i,
  input  logic signed [SAMPLE_BITS-1:0]  right_in_i,
  input  logic                           last_in_block_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]  left_out_o,
  output logic signed [SAMPLE_BITS-1:0]  right_out_o,
  output logic                           meters_valid_o,
  output logic [SAMPLE_BITS-1:0]         peak_left_o,
  output logic [SAMPLE_BITS-1:0]         peak_right_o,
  output logic [SAMPLE_BITS-1:0]         vu_left_o,
  output logic [SAMPLE_BITS-1:0]         vu_right_o
);
  import sgr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // configuration is always taken
  assign cfg_ready_o = 1'b1;

  sgr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  sgr_dp #(
    .MAX_BLOCK  (MAX_BLOCK),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .left_in_i      (left_in_i),
    .right_in_i     (right_in_i),
    .last_in_block_i(last_in_block_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .left_out_o     (left_out_o),
    .right_out_o    (right_out_o),
    .meters_valid_o (meters_valid_o),
    .peak_left_o    (peak_left_o),
    .peak_right_o   (peak_right_o),
    .vu_left_o      (vu_left_o),
    .vu_right_o     (vu_right_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stereo gain ramp and peak/VU meter. Sample pairs
// are streamed through random idle and stall gaps. A local model of the gain
// ramps, saturation and block metering predicts every output transaction,
// which is then compared over all its fields. Register settings change between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import sgr_pkg::*;

  localparam int  PERIOD      = 12;
  localparam int  SW          = SAMPLE_BITS_DEF;
  localparam int  BLOCK_LIMIT = MAX_BLOCK_DEF;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED = 3'd7;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE    = 3'd5;
  localparam int  RAMP_FADER = 0;
  localparam int  RAMP_LEFT  = 1;
  localparam int  RAMP_RIGHT = 2;

  typedef struct {
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
    logic                 last;
  } pair_t;

  typedef struct packed {
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
    logic                 meters;
    logic [SW-1:0]        pk_l;
    logic [SW-1:0]        pk_r;
    logic [SW-1:0]        vu_l;
    logic [SW-1:0]        vu_r;
  } gained_t;

  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic in_valid_i, in_stall_o;
  logic signed [SW-1:0] left_in_i, right_in_i;
  logic last_in_block_i;
  logic out_valid_o, out_stall_i;
  logic signed [SW-1:0] left_out_o, right_out_o;
  logic meters_valid_o;
  logic [SW-1:0] peak_left_o, peak_right_o, vu_left_o, vu_right_o;

  stereo_gain_ramp_with_peak_vu_meter_top uut (.*);

  // model state
  longint gain_target[3];
  longint gain_cur[3];
  longint gain_applied[3];
  longint gain_delta[3];
  longint gain_left[3];
  longint ramp_len, vu_coef;
  longint peak_acc[2];
  longint unsigned sq_acc[2];
  longint pair_count;
  longint vu_acc[2];

  pair_t   pending_pairs[$];
  gained_t expected_out[$];
  int      idle_pct;
  int      mismatches;
  longint  cycles;
  logic    in_taken;

  // advance one gain ramp by a sample
  function automatic longint step_ramp(int k);
    longint n;
    if (gain_target[k] != gain_applied[k]) begin
      n = (ramp_len == 0) ? 1 : ramp_len;
      gain_applied[k] = gain_target[k];
      gain_left[k] = n;
      gain_delta[k] = (gain_target[k] - gain_cur[k]) / n;
    end
    if (gain_left[k] == 0) begin
      gain_cur[k] = gain_applied[k];
    end else begin
      gain_left[k]--;
      gain_cur[k] = (gain_left[k] > 0) ? gain_cur[k] + gain_delta[k] : gain_applied[k];
    end
    return gain_cur[k];
  endfunction

  function automatic longint scale_sample(longint x, longint bal, longint fad);
    longint g, y;
    g = (bal * fad + (64'sd1 <<< 19)) >>> 20;
    y = (x * g + (64'sd1 <<< 19)) >>> 20;
    if (y > 64'sd8388607) y = 64'sd8388607;
    if (y < -64'sd8388608) y = -64'sd8388608;
    return y;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // work out the output transaction for one accepted pair
  function automatic gained_t predict_gain(pair_t p);
    gained_t e;
    longint fg, gl, gr, mag;
    longint y[2];
    longint unsigned rms;
    fg = step_ramp(RAMP_FADER);
    gl = step_ramp(RAMP_LEFT);
    gr = step_ramp(RAMP_RIGHT);
    y[0] = scale_sample(longint'(p.left), gl, fg);
    y[1] = scale_sample(longint'(p.right), gr, fg);
    for (int c = 0; c < 2; c++) begin
      mag = (y[c] < 0) ? -y[c] : y[c];
      if (mag > peak_acc[c]) peak_acc[c] = mag;
      sq_acc[c] += longint'(mag * mag);
    end
    pair_count++;
    e = '{left: y[0][SW-1:0], right: y[1][SW-1:0], default: '0};
    if (p.last || pair_count >= BLOCK_LIMIT) begin
      for (int c = 0; c < 2; c++) begin
        rms = int_sqrt(sq_acc[c] / longint'(pair_count));
        vu_acc[c] = (vu_coef * vu_acc[c] + (65536 - vu_coef) * longint'(rms)
                     + 32768) >>> 16;
        sq_acc[c] = 0;
      end
      e.meters = 1'b1;
      e.pk_l = peak_acc[0][SW-1:0];
      e.pk_r = peak_acc[1][SW-1:0];
      e.vu_l = vu_acc[0][SW-1:0];
      e.vu_r = vu_acc[1][SW-1:0];
      peak_acc[0] = 0;
      peak_acc[1] = 0;
      pair_count = 0;
    end
    return e;
  endfunction

  // clock
  initial begin
    clk_i = 1'b0;
    forever #(PERIOD / 2) clk_i = ~clk_i;
  end

  // drive the next pair at the falling edge; hold a stalled one
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_pairs.size() > 0 && $urandom_range(99) >= idle_pct) begin
        left_in_i       <= pending_pairs[0].left;
        right_in_i      <= pending_pairs[0].right;
        last_in_block_i <= pending_pairs[0].last;
        in_valid_i      <= 1'b1;
        void'(pending_pairs.pop_front());
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= rst_ni && ($urandom_range(99) < idle_pct);
  end

  // predict on input transactions, check output transactions
  always @(posedge clk_i or negedge rst_ni) begin
    gained_t e;
    gained_t a;
    pair_t   p;
    if (!rst_ni) begin
      in_taken <= 1'b0;
      cycles   <= 0;
    end else begin
      cycles   <= cycles + 1;
      in_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        p = '{left: left_in_i, right: right_in_i, last: last_in_block_i};
        expected_out.push_back(predict_gain(p));
      end
      if (out_valid_o && !out_stall_i) begin
        a = '{left: left_out_o, right: right_out_o, meters: meters_valid_o,
              pk_l: peak_left_o, pk_r: peak_right_o, vu_l: vu_left_o, vu_r: vu_right_o};
        if (expected_out.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected output transaction at cycle %0d", cycles);
        end else begin
          e = expected_out.pop_front();
          if (a !== e) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch cycle %0d exp l=%0d r=%0d m=%0b pk=%0d/%0d vu=%0d/%0d",
                        " act l=%0d r=%0d m=%0b pk=%0d/%0d vu=%0d/%0d"},
                       cycles, e.left, e.right, e.meters, e.pk_l, e.pk_r, e.vu_l, e.vu_r,
                       a.left, a.right, a.meters, a.pk_l, a.pk_r, a.vu_l, a.vu_r);
          end
        end
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("FAIL stereo_gain_ramp_with_peak_vu_meter_top");
        $finish;
      end
    end
  end

  // write one register while idle and mirror it in the model
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_FADER:     gain_target[RAMP_FADER] = val;
      REG_PAN_LEFT:  gain_target[RAMP_LEFT]  = val;
      REG_PAN_RIGHT: gain_target[RAMP_RIGHT] = val;
      REG_RAMP:      ramp_len = val[STEP_W-1:0];
      REG_VU_ALPHA:  vu_coef  = val[ALPHA_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_pairs.size() == 0 && !in_valid_i && expected_out.size() == 0);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [SW-1:0] rand_sample();
    case ($urandom_range(3))
      0: return SW'($urandom_range(4095) - 2048);
      1: return $urandom_range(1) ? 24'h7fffff : 24'h800000;
      default: return SW'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_gain();
    case ($urandom_range(3))
      0: return CFG_DATA_W'(UNITY + $urandom_range(65535) - 32768);
      1: return CFG_DATA_W'($urandom_range(2097152));
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  task automatic queue_pair(logic [SW-1:0] l, logic [SW-1:0] r, logic last);
    pending_pairs.push_back('{left: l, right: r, last: last});
  endtask

  initial begin
    int steps;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    left_in_i = '0;
    right_in_i = '0;
    last_in_block_i = 1'b0;
    out_stall_i = 1'b0;
    mismatches = 0;
    idle_pct = 13;
    for (int k = 0; k < 3; k++) begin
      gain_target[k] = UNITY;
      gain_cur[k] = UNITY;
      gain_applied[k] = UNITY;
      gain_delta[k] = 0;
      gain_left[k] = 0;
    end
    ramp_len = RAMP_STEPS_RST;
    vu_coef = VU_ALPHA_RST;
    for (int c = 0; c < 2; c++) begin
      peak_acc[c] = 0;
      sq_acc[c] = 0;
      vu_acc[c] = 0;
    end
    pair_count = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: extremes, single-sample block
    queue_pair(24'h7fffff, 24'h800000, 1'b1);
    queue_pair(24'h000000, 24'hffffff, 1'b0);
    queue_pair(24'h800000, 24'h7fffff, 1'b0);
    queue_pair(24'h000001, 24'h555555, 1'b1);
    drain();

    // full gain, mute left, one-sample ramp, no smoothing: saturation
    write_reg(REG_FADER, 24'hffffff);
    write_reg(REG_PAN_LEFT, 24'h000000);
    write_reg(REG_PAN_RIGHT, 24'hffffff);
    write_reg(REG_RAMP, 24'd1);
    write_reg(REG_VU_ALPHA, 24'd0);
    write_reg(IDX_UNMAPPED, 24'h123456);
    queue_pair(24'h7fffff, 24'h7fffff, 1'b0);
    queue_pair(24'h800000, 24'h800000, 1'b0);
    queue_pair(24'h000001, 24'hffffff, 1'b1);
    queue_pair(24'haaaaaa, 24'h555555, 1'b1);
    drain();

    // zero ramp length acts as one; fader to zero; heaviest smoothing
    write_reg(REG_RAMP, 24'd0);
    write_reg(REG_FADER, 24'h000000);
    write_reg(REG_VU_ALPHA, 24'hffff);
    write_reg(IDX_SPARE, 24'hffffff);
    queue_pair(24'h7fffff, 24'h800000, 1'b0);
    queue_pair(24'h123456, 24'h654321, 1'b1);
    drain();

    // long ramp that is still moving
    write_reg(REG_RAMP, 24'hffff);
    write_reg(REG_FADER, UNITY);
    write_reg(REG_PAN_LEFT, UNITY);
    write_reg(REG_PAN_RIGHT, 24'd0);
    for (int i = 0; i < 10; i++) queue_pair(rand_sample(), rand_sample(), i % 4 == 3);
    drain();

    // random phases with fresh settings
    for (int ph = 0; ph < 9; ph++) begin
      idle_pct = (ph == 4) ? 0 : 13;
      case ($urandom_range(4))
        0: steps = 1;
        1: steps = $urandom_range(8);
        2: steps = $urandom_range(200);
        3: steps = 65535;
        default: steps = $urandom_range(65535);
      endcase
      write_reg(REG_RAMP, CFG_DATA_W'(steps));
      write_reg(REG_FADER, rand_gain());
      write_reg(REG_PAN_LEFT, rand_gain());
      write_reg(REG_PAN_RIGHT, rand_gain());
      write_reg(REG_VU_ALPHA,
                ($urandom_range(3) == 0) ? 24'hffff : CFG_DATA_W'($urandom_range(65535)));
      for (int i = 0; i < 110; i++)
        queue_pair(rand_sample(), rand_sample(), $urandom_range(15) == 0);
      drain();
    end

    wait (pending_pairs.size() == 0 && !in_valid_i && expected_out.size() == 0);
    repeat (300) @(negedge clk_i);
    if (mismatches == 0 && expected_out.size() == 0) begin
      $display("PASS stereo_gain_ramp_with_peak_vu_meter_top");
    end else begin
      $display("FAIL stereo_gain_ramp_with_peak_vu_meter_top");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/sgr_pkg.sv
design/sgr_iter.sv
design/sgr_dp.sv
design/sgr_ctrl.sv
design/stereo_gain_ramp_with_peak_vu_meter_top.sv
tb/tb.sv
